FILE: design/assert_macros.svh
// Assertion macros shared by the synthesizer word calculator.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FNSW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define FNSW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/fnsw_pkg.sv
// Package for the fractional-N synthesizer word calculator.
// Holds widths, band thresholds and the divider pipeline payload type; no dependencies.
`timescale 1ns / 1ps
package fnsw_pkg;

  localparam int FNSW_XW    = 26;   // crystal width
  localparam int FNSW_CW    = 30;   // carrier width
  localparam int FNSW_DVW   = 20;   // deviation width
  localparam int FNSW_FRACB = 19;   // fraction bits below the 2^19 offset
  localparam int FNSW_NW    = FNSW_CW + FNSW_FRACB;  // dividend width, 49
  localparam int FNSW_RW    = FNSW_XW + 1;           // partial remainder width
  localparam int FNSW_NSTEP = FNSW_NW;               // one quotient bit a step
  localparam int FNSW_STEPS_PER_STAGE = 4;

  localparam logic [FNSW_XW-1:0] FNSW_XTAL_RESET = 26'd30000000;

  localparam logic [FNSW_CW-1:0] FNSW_TH0 = 30'd705000000;
  localparam logic [FNSW_CW-1:0] FNSW_TH1 = 30'd525000000;
  localparam logic [FNSW_CW-1:0] FNSW_TH2 = 30'd353000000;
  localparam logic [FNSW_CW-1:0] FNSW_TH3 = 30'd239000000;
  localparam logic [FNSW_CW-1:0] FNSW_TH4 = 30'd177000000;

  localparam logic [2:0] BAND_DIV4  = 3'd0;
  localparam logic [2:0] BAND_DIV6  = 3'd1;
  localparam logic [2:0] BAND_DIV8  = 3'd2;
  localparam logic [2:0] BAND_DIV12 = 3'd3;
  localparam logic [2:0] BAND_DIV16 = 3'd4;
  localparam logic [2:0] BAND_DIV24 = 3'd5;

  localparam logic [31:0] FNSW_RECIP3  = 32'hAAAAAAAB;  // x/3  = (x*c) >> 33
  localparam logic [31:0] FNSW_RECIP10 = 32'hCCCCCCCD;  // x/10 = (x*c) >> 35
  localparam logic [23:0] FNSW_DEV_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [2:0]          band;
    logic                pfd_zero;
    logic                xtal_zero;
    logic [FNSW_XW-1:0]  modulo;
    logic [FNSW_XW-1:0]  pfd;
    logic [FNSW_XW-1:0]  xtal;
    logic [FNSW_RW-1:0]  rem_m;   // carrier/pfd partial remainder
    logic [FNSW_NW-1:0]  num_m;   // dividend bits out, quotient bits in
    logic [FNSW_RW-1:0]  rem_d;   // deviation/crystal partial remainder
    logic [FNSW_NW-1:0]  num_d;
  } fnsw_div_t;

endpackage

FILE: design/fnsw_div_stage.sv
// One register stage of the two parallel restoring dividers.
// Depends on fnsw_pkg for the payload type and widths.
`timescale 1ns / 1ps
module fnsw_div_stage import fnsw_pkg::*; #(
  parameter int STEP_BASE = 0,
  parameter int STEPS     = FNSW_STEPS_PER_STAGE
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      valid_in,
  input  fnsw_div_t data_in,
  output logic      valid_out,
  output fnsw_div_t data_out
);

  fnsw_div_t work;

  always_comb begin
    logic [FNSW_RW-1:0] r;
    work = data_in;
    for (int j = 0; j < STEPS; j++) begin
      if (STEP_BASE + j < FNSW_NSTEP) begin
        r = {work.rem_m[FNSW_RW-2:0], work.num_m[FNSW_NW-1]};
        if (r >= {1'b0, work.pfd}) begin
          work.rem_m = r - {1'b0, work.pfd};
          work.num_m = {work.num_m[FNSW_NW-2:0], 1'b1};
        end else begin
          work.rem_m = r;
          work.num_m = {work.num_m[FNSW_NW-2:0], 1'b0};
        end
        r = {work.rem_d[FNSW_RW-2:0], work.num_d[FNSW_NW-1]};
        if (r >= {1'b0, work.xtal}) begin
          work.rem_d = r - {1'b0, work.xtal};
          work.num_d = {work.num_d[FNSW_NW-2:0], 1'b1};
        end else begin
          work.rem_d = r;
          work.num_d = {work.num_d[FNSW_NW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
    if (en) begin
      data_out <= work;
    end
  end

endmodule

FILE: design/fractional_n_synth_word_calc_unit.sv
// Fractional-N synthesizer word calculator, top level.
// Pipeline: stage 0, stage 1, the divider stages and the output register.
// Throughput: one item per cycle unless out_ready stalls; divider steps set depth, not rate.
// Reset (rst, synchronous): empties the pipeline and loads the crystal register with 30 MHz.
// Depends on fnsw_pkg, fnsw_div_stage and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fractional_n_synth_word_calc_unit import fnsw_pkg::*; #(
  parameter int STEPS_PER_STAGE = FNSW_STEPS_PER_STAGE
) (
  input  logic                clk,
  input  logic                rst,
  // configuration: crystal frequency
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [FNSW_XW-1:0]  crystal_hz,
  // input items
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FNSW_CW-1:0]  carrier_hz,
  input  logic [FNSW_DVW-1:0] deviation_hz,
  // result items
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          band_code,
  output logic [7:0]          integer_word,
  output logic [19:0]         fraction_word,
  output logic [23:0]         deviation_word,
  output logic [25:0]         modulo_word,
  output logic                range_error
);

  localparam int NDS = (FNSW_NSTEP + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int DNW = FNSW_DVW + 5 + 18;   // 2^18 * outdiv * deviation

  // The whole pipeline moves together; the output register is the last stage,
  // so a new transfer is taken whenever the result is taken or there is none.
  logic adv;
  assign adv      = out_ready || !out_valid;
  assign in_ready = adv;
  assign cfg_ready = 1'b1;

  logic [FNSW_XW-1:0] xtal_reg;
  always_ff @(posedge clk) begin
    if (rst) begin
      xtal_reg <= FNSW_XTAL_RESET;
    end else if (cfg_valid) begin
      xtal_reg <= crystal_hz;
    end
  end

  // Stage 0: band pick from the thresholds and the deviation numerator.
  logic [2:0] band_c;
  logic [4:0] od_c;
  always_comb begin
    band_c = BAND_DIV4;  od_c = 5'd4;
    if (carrier_hz < FNSW_TH0) begin band_c = BAND_DIV6;  od_c = 5'd6;  end
    if (carrier_hz < FNSW_TH1) begin band_c = BAND_DIV8;  od_c = 5'd8;  end
    if (carrier_hz < FNSW_TH2) begin band_c = BAND_DIV12; od_c = 5'd12; end
    if (carrier_hz < FNSW_TH3) begin band_c = BAND_DIV16; od_c = 5'd16; end
    if (carrier_hz < FNSW_TH4) begin band_c = BAND_DIV24; od_c = 5'd24; end
  end

  logic               s0_valid;
  logic [2:0]         s0_band;
  logic [FNSW_CW-1:0] s0_carrier;
  logic [DNW-1:0]     s0_devnum;
  logic [FNSW_XW-1:0] s0_xtal;
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in_valid;
    end
    if (adv) begin
      s0_band    <= band_c;
      s0_carrier <= carrier_hz;
      s0_devnum  <= {(25'(od_c) * 25'(deviation_hz)), 18'd0};
      s0_xtal    <= xtal_reg;
    end
  end

  // Stage 1: phase-detector frequency. 2*xtal/outdiv is xtal/2, /3, /4, /6, /8
  // or /12; the thirds come from one reciprocal product, the modulo word from another.
  logic [63:0]        prod3, prod10;
  logic [FNSW_XW-1:0] third, pfd_c;
  fnsw_div_t          s1_c;
  assign prod3  = 64'(s0_xtal) * 64'(FNSW_RECIP3);
  assign prod10 = 64'(s0_xtal) * 64'(FNSW_RECIP10);
  assign third  = prod3[33 +: FNSW_XW];
  always_comb begin
    unique case (s0_band)
      BAND_DIV4:  pfd_c = s0_xtal >> 1;
      BAND_DIV6:  pfd_c = third;
      BAND_DIV8:  pfd_c = s0_xtal >> 2;
      BAND_DIV12: pfd_c = third >> 1;
      BAND_DIV16: pfd_c = s0_xtal >> 3;
      BAND_DIV24: pfd_c = third >> 2;
      default:    pfd_c = '0;
    endcase
    s1_c.band      = s0_band;
    s1_c.pfd_zero  = (pfd_c == '0);
    s1_c.xtal_zero = (s0_xtal == '0);
    s1_c.modulo    = prod10[35 +: FNSW_XW];
    s1_c.pfd       = pfd_c;
    s1_c.xtal      = s0_xtal;
    s1_c.rem_m     = '0;
    s1_c.num_m     = {s0_carrier, {FNSW_FRACB{1'b0}}};
    s1_c.rem_d     = '0;
    s1_c.num_d     = {{(FNSW_NW-DNW){1'b0}}, s0_devnum};
  end

  logic      s1_valid;
  fnsw_div_t s1_data;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s0_valid;
    end
    if (adv) begin
      s1_data <= s1_c;
    end
  end

  logic      dv [NDS+1];
  fnsw_div_t dd [NDS+1];
  assign dv[0] = s1_valid;
  assign dd[0] = s1_data;

  // Long division stages: both quotients grow by up to STEPS_PER_STAGE bits each stage.
  for (genvar s = 0; s < NDS; s++) begin : g_div
    fnsw_div_stage #(
      .STEP_BASE(s * STEPS_PER_STAGE),
      .STEPS    (STEPS_PER_STAGE)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .valid_in (dv[s]),
      .data_in  (dd[s]),
      .valid_out(dv[s+1]),
      .data_out (dd[s+1])
    );
  end

  // Output stage: the carrier quotient sits above the 19 fraction bits.
  fnsw_div_t          fin;
  logic [FNSW_CW-1:0] q;
  logic [7:0]         iw_c;
  logic [19:0]        fw_c;
  logic [23:0]        dw_c;
  logic               err_c;
  assign fin = dd[NDS];
  assign q   = fin.num_m[FNSW_NW-1:FNSW_FRACB];
  always_comb begin
    err_c = 1'b0;
    iw_c  = '0;
    fw_c  = '0;
    if (fin.pfd_zero || q == '0) begin
      err_c = 1'b1;
    end else begin
      if (q > 30'd256) begin
        iw_c  = 8'hFF;
        err_c = 1'b1;
      end else begin
        iw_c = 8'(q - 30'd1);
      end
      fw_c = {1'b1, fin.num_m[FNSW_FRACB-1:0]};
    end
    if (fin.xtal_zero) begin
      dw_c  = '0;
      err_c = 1'b1;
    end else if (fin.num_d > FNSW_NW'(FNSW_DEV_MAX)) begin
      dw_c  = FNSW_DEV_MAX;
      err_c = 1'b1;
    end else begin
      dw_c = fin.num_d[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv[NDS];
    end
    if (adv) begin
      band_code      <= fin.band;
      integer_word   <= iw_c;
      fraction_word  <= fw_c;
      deviation_word <= dw_c;
      modulo_word    <= fin.modulo;
      range_error    <= err_c;
    end
  end

  // A valid result without error always carries the 2^19 offset.
  `FNSW_ASSERT_IMP(a_frac_offset, out_valid && !range_error, fraction_word[19], "fraction offset missing")
  // Band codes above five never leave the block.
  `FNSW_ASSERT_IMP(a_band_range, out_valid, band_code <= 3'd5, "band code out of range")
  // While input is held off, the first stage must keep what it has.
  `FNSW_ASSERT_NXT(a_stall_hold, !in_ready, $stable(s0_valid) && $stable(s0_carrier), "stage 0 moved in a stall")

endmodule

FILE: tb/fractional_n_synth_word_calc_unit_test.sv
// Testbench for the fractional-N synthesizer word calculator.
// Drives carrier/deviation transfers and crystal writes, predicts every result word.
// Depends on fnsw_pkg and the fractional_n_synth_word_calc_unit RTL.
`timescale 1ns / 1ps

module fractional_n_synth_word_calc_unit_test;
  import fnsw_pkg::*;

  // One predicted set of synthesizer words.
  typedef struct packed {
    logic [2:0]  band;
    logic [7:0]  int_word;
    logic [19:0] frac_word;
    logic [23:0] dev_word;
    logic [25:0] mod_word;
    logic        err;
  } synth_words_t;

  // Holds the crystal setting, computes the words for each carrier transfer and
  // checks the block's results in order.
  class synth_word_board;
    logic [FNSW_XW-1:0] xtal;
    synth_words_t       pending[$];
    int                 mismatches;
    int                 checked;

    function new();
      xtal = FNSW_XTAL_RESET;
      mismatches = 0;
      checked = 0;
    endfunction

    function void note_crystal(logic [FNSW_XW-1:0] hz);
      xtal = hz;
    endfunction

    // Exact integer version of the divider arithmetic.
    function void note_carrier(logic [FNSW_CW-1:0] carrier, logic [FNSW_DVW-1:0] dev);
      synth_words_t w;
      longint unsigned outdiv, pfd, q, r, iv, dv;
      w = '0;
      if (carrier >= FNSW_TH0) begin
        w.band = BAND_DIV4; outdiv = 4;
      end else if (carrier >= FNSW_TH1) begin
        w.band = BAND_DIV6; outdiv = 6;
      end else if (carrier >= FNSW_TH2) begin
        w.band = BAND_DIV8; outdiv = 8;
      end else if (carrier >= FNSW_TH3) begin
        w.band = BAND_DIV12; outdiv = 12;
      end else if (carrier >= FNSW_TH4) begin
        w.band = BAND_DIV16; outdiv = 16;
      end else begin
        w.band = BAND_DIV24; outdiv = 24;
      end
      pfd = (2 * longint'(xtal)) / outdiv;
      if (pfd == 0) begin
        w.err = 1'b1;
      end else begin
        q = longint'(carrier) / pfd;
        r = longint'(carrier) % pfd;
        if (q == 0) begin
          w.err = 1'b1;
        end else begin
          iv = q - 1;
          if (iv > 255) begin
            iv = 255;
            w.err = 1'b1;
          end
          w.int_word = iv[7:0];
          w.frac_word = 20'(((r + pfd) << 19) / pfd);
        end
      end
      if (xtal == 0) begin
        w.err = 1'b1;
      end else begin
        dv = ((64'd262144 * outdiv) * longint'(dev)) / longint'(xtal);
        if (dv > FNSW_DEV_MAX) begin
          dv = 64'(FNSW_DEV_MAX);
          w.err = 1'b1;
        end
        w.dev_word = dv[23:0];
      end
      w.mod_word = 26'(longint'(xtal) / 10);
      pending.push_back(w);
    endfunction

    function void check_result(synth_words_t got);
      synth_words_t exp_w;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result %h", got);
        return;
      end
      exp_w = pending.pop_front();
      checked++;
      if (got !== exp_w) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: band %0d/%0d int %0d/%0d frac %0d/%0d dev %0d/%0d mod %0d/%0d err %b/%b",
                   exp_w.band, got.band, exp_w.int_word, got.int_word,
                   exp_w.frac_word, got.frac_word, exp_w.dev_word, got.dev_word,
                   exp_w.mod_word, got.mod_word, exp_w.err, got.err);
      end
    endfunction
  endclass

  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [FNSW_XW-1:0] crystal_hz = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [FNSW_CW-1:0] carrier_hz = '0;
  logic [FNSW_DVW-1:0] deviation_hz = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0]  band_code;
  logic [7:0]  integer_word;
  logic [19:0] fraction_word;
  logic [23:0] deviation_word;
  logic [25:0] modulo_word;
  logic        range_error;

  // Idle and stall percentages, changed per phase; hold_off forces a long stall.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int items_sent = 0;
  int crystal_writes = 0;

  synth_word_board board = new();

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  fractional_n_synth_word_calc_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .crystal_hz(crystal_hz),
    .in_valid(in_valid), .in_ready(in_ready),
    .carrier_hz(carrier_hz), .deviation_hz(deviation_hz),
    .out_valid(out_valid), .out_ready(out_ready),
    .band_code(band_code), .integer_word(integer_word), .fraction_word(fraction_word),
    .deviation_word(deviation_word), .modulo_word(modulo_word), .range_error(range_error)
  );

  // Result side: sample at the rising edge, choose ready at the falling edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_result({band_code, integer_word, fraction_word,
                          deviation_word, modulo_word, range_error});
  end

  always @(negedge clk) begin
    out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // One carrier transfer after a random idle stretch; valid stays up until
  // accepted, and is dropped only by the next idle cycle or a drain.
  task automatic send_carrier(logic [FNSW_CW-1:0] carrier, logic [FNSW_DVW-1:0] dev);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    carrier_hz <= carrier;
    deviation_hz <= dev;
    do @(posedge clk); while (!in_ready);
    board.note_carrier(carrier, dev);
    items_sent++;
    @(negedge clk);
  endtask

  // Crystal writes happen only with the pipeline empty.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_crystal(logic [FNSW_XW-1:0] hz);
    wait_drained();
    cfg_valid <= 1'b1;
    crystal_hz <= hz;
    do @(posedge clk); while (!cfg_ready);
    board.note_crystal(hz);
    crystal_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random carrier: mostly in range, sometimes anywhere in 30 bits; deviation similar.
  task automatic send_random(int n);
    logic [FNSW_CW-1:0] c;
    logic [FNSW_DVW-1:0] d;
    repeat (n) begin
      case ($urandom_range(9))
        0: c = FNSW_CW'($urandom);
        1: c = FNSW_TH0 - 30'd1 + FNSW_CW'($urandom_range(2));
        2: c = FNSW_TH4 - 30'd1 + FNSW_CW'($urandom_range(2));
        default: c = FNSW_CW'($urandom_range(1050000000, 100000000));
      endcase
      d = ($urandom_range(4) == 0) ? FNSW_DVW'($urandom)
                                   : FNSW_DVW'($urandom_range(1000000));
      send_carrier(c, d);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset crystal, extremes, band edges and the error cases.
    send_carrier(30'd100000000, 20'd0);
    send_carrier(30'd1050000000, 20'd1000000);
    send_carrier(FNSW_TH0, 20'd5000);
    send_carrier(FNSW_TH0 - 30'd1, 20'd5000);
    send_carrier(FNSW_TH1, 20'd1);
    send_carrier(FNSW_TH1 - 30'd1, 20'd1);
    send_carrier(FNSW_TH2 - 30'd1, 20'd77);
    send_carrier(FNSW_TH3 - 30'd1, 20'd77);
    send_carrier(FNSW_TH4, 20'hFFFFF);
    send_carrier(FNSW_TH4 - 30'd1, 20'hFFFFF);
    send_carrier(30'd0, 20'd0);                // carrier below pfd
    send_carrier(30'h3FFFFFFF, 20'hFFFFF);     // largest 30-bit carrier

    write_crystal(26'd10000000);
    send_carrier(30'd1050000000, 20'hFFFFF);   // high carrier, full-scale deviation
    send_carrier(30'd100000000, 20'd1000000);
    write_crystal(26'd0);                      // zero crystal
    send_carrier(30'd400000000, 20'd1000);
    write_crystal(26'd11);                     // zero pfd only for divide-by-24
    send_carrier(30'd100000000, 20'd3);
    send_carrier(30'd800000000, 20'd3);
    write_crystal(26'h3FFFFFF);
    send_carrier(30'd100000000, 20'd1000000);
    send_carrier(30'h3FFFFFFF, 20'hAAAAA);
    write_crystal(26'd40000000);
    send_carrier(30'd900000000, 20'h55555);

    // Random phases with different idling, plus crystal changes between them.
    send_random(150);
    write_crystal(26'd26000000);
    send_idle_pct = 79;
    send_random(120);
    write_crystal(FNSW_XW'($urandom_range(40000000, 10000000)));
    send_idle_pct = 0; recv_stall_pct = 79;
    send_random(150);
    write_crystal(FNSW_XW'($urandom));
    send_idle_pct = 30; recv_stall_pct = 30;
    send_random(120);
    // Sender pauses until every result is back.
    wait_drained();
    write_crystal(26'd40000000);
    send_idle_pct = 0; recv_stall_pct = 0;
    // Receiver holds off long enough that the pipeline fills and in_ready drops.
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(negedge clk);
        hold_off = 1'b0;
      end
      send_random(60);
    join
    write_crystal(26'd30000000);
    send_random(100);

    wait_drained();
    $display("Covered %0d carrier transfers over %0d crystal settings, with band edges,",
             items_sent, crystal_writes + 1);
    $display("zero pfd, low carrier, word overflows and stalls on both sides.");
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/fnsw_pkg.sv
design/fnsw_div_stage.sv
design/fractional_n_synth_word_calc_unit.sv
tb/fractional_n_synth_word_calc_unit_test.sv
